// File: hw/rtl/sound_cpu_io_timer_block_unit_macros.svh
// ----------------------------------------------------------------------------
// Sound CPU I/O timer block assertion macros
// Shared property wrappers on clk_i with rst_ni as the disable condition.
// ----------------------------------------------------------------------------
`ifndef SOUND_CPU_IO_TIMER_BLOCK_UNIT_MACROS_SVH
`define SOUND_CPU_IO_TIMER_BLOCK_UNIT_MACROS_SVH

// Same-cycle implication.
`define SCIT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scit assertion failed");

// Next-cycle implication.
`define SCIT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scit assertion failed");

`endif

// File: hw/rtl/scit_pkg.sv
// ----------------------------------------------------------------------------
// Sound CPU I/O timer block package
// Item types, function codes, I/O register offsets and timer constants.
// ----------------------------------------------------------------------------
`default_nettype none

package scit_pkg;

  localparam int unsigned DspWords     = 128;
  localparam int unsigned DspAddrW     = 7;
  localparam int unsigned SlowPrescale = 128;
  localparam int unsigned FastPrescale = 16;
  localparam int unsigned PrescW       = 7;
  localparam int unsigned NumTimers    = 3;
  localparam logic [8:0]  GoalMax      = 9'h100;

  typedef enum logic [2:0] {
    FUNC_CPU_RD   = 3'd0,
    FUNC_CPU_WR   = 3'd1,
    FUNC_TICK     = 3'd2,
    FUNC_HOST_WR  = 3'd3,
    FUNC_HOST_RD  = 3'd4
  } func_e;

  localparam logic [3:0] AddrControl  = 4'h1;
  localparam logic [3:0] AddrDspIndex = 4'h2;
  localparam logic [3:0] AddrDspData  = 4'h3;
  localparam logic [3:0] AddrPort0    = 4'h4;
  localparam logic [3:0] AddrPort1    = 4'h5;
  localparam logic [3:0] AddrPort2    = 4'h6;
  localparam logic [3:0] AddrPort3    = 4'h7;
  localparam logic [3:0] AddrScratch0 = 4'h8;
  localparam logic [3:0] AddrScratch1 = 4'h9;
  localparam logic [3:0] AddrGoal0    = 4'hA;
  localparam logic [3:0] AddrGoal1    = 4'hB;
  localparam logic [3:0] AddrGoal2    = 4'hC;
  localparam logic [3:0] AddrEvent0   = 4'hD;
  localparam logic [3:0] AddrEvent1   = 4'hE;
  localparam logic [3:0] AddrEvent2   = 4'hF;

  localparam int unsigned CtlPortsLoBit = 4;
  localparam int unsigned CtlPortsHiBit = 5;
  localparam int unsigned CtlRomBit     = 7;
  localparam int unsigned DspLockBit    = 7;

  typedef struct packed {
    logic [2:0] func;
    logic [3:0] io_address;
    logic [7:0] write_data;
    logic [1:0] port_select;
    logic [3:0] tick_cycles;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       rom_overlay;
  } out_item_t;

  typedef struct packed {
    logic       tick;
    logic [3:0] cycles;
    logic       ctl_wr;
    logic       en;
    logic       goal_wr;
    logic [7:0] goal;
    logic       evt_rd;
  } tmr_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/sound_cpu_io_timer_block_unit.sv
// A transfer accepted into the input register moves its result into the output register
// when the output stage is free; a stall on the output holds both registers.
// Throughput: one item per cycle unless stalled; the I/O page and timers update in a single pass.
// Reset: all page registers and timers clear, timer goals go to 256, and the
// DSP store reads zero per entry until written, with no clearing pass.
// ----------------------------------------------------------------------------
// Sound CPU I/O page with interval timers
// CPU and host access to control, DSP, port, scratch and timer registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sound_cpu_io_timer_block_unit_macros.svh"

module sound_cpu_io_timer_block_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire scit_pkg::in_item_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output scit_pkg::out_item_t     out_data_o
);

  logic                item_valid_q;
  scit_pkg::in_item_t  item_q;
  logic                out_valid_q;
  scit_pkg::out_item_t out_q, out_d;
  logic                dsp_sel_q, dsp_sel_d;
  logic                stage_ready;
  logic                adv;

  logic [7:0]          control_q, control_d;
  logic [7:0]          dsp_index_q, dsp_index_d;
  logic [7:0]          h2c_q [4];
  logic [7:0]          h2c_d [4];
  logic [7:0]          c2h_q [4];
  logic [7:0]          c2h_d [4];
  logic [7:0]          scratch_q [2];
  logic [7:0]          scratch_d [2];

  logic                is_rd, is_wr, is_tick, is_hwr, is_hrd;
  logic                dsp_wr;
  logic [7:0]          dsp_rdata;
  logic [3:0]          evt [scit_pkg::NumTimers];
  scit_pkg::tmr_ctl_t  tmr_ctl [scit_pkg::NumTimers];

  assign stage_ready = !out_valid_q || !out_stall_i;
  assign adv         = item_valid_q && stage_ready;
  assign in_stall_o  = item_valid_q && !stage_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      dsp_sel_q    <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        item_valid_q <= in_valid_i;
      end
      if (stage_ready) begin
        out_valid_q <= item_valid_q;
        dsp_sel_q   <= dsp_sel_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_data_i;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    is_rd   = 1'b0;
    is_wr   = 1'b0;
    is_tick = 1'b0;
    is_hwr  = 1'b0;
    is_hrd  = 1'b0;
    case (scit_pkg::func_e'(item_q.func))
      scit_pkg::FUNC_CPU_RD:  is_rd   = adv;
      scit_pkg::FUNC_CPU_WR:  is_wr   = adv;
      scit_pkg::FUNC_TICK:    is_tick = adv;
      scit_pkg::FUNC_HOST_WR: is_hwr  = adv;
      scit_pkg::FUNC_HOST_RD: is_hrd  = adv;
      default: ;
    endcase
  end

  always_comb begin
    control_d   = control_q;
    dsp_index_d = dsp_index_q;
    h2c_d       = h2c_q;
    c2h_d       = c2h_q;
    scratch_d   = scratch_q;
    dsp_wr      = 1'b0;
    dsp_sel_d   = 1'b0;
    out_d.read_data = 8'd0;

    if (is_rd) begin
      case (item_q.io_address)
        scit_pkg::AddrDspIndex: out_d.read_data = dsp_index_q;
        scit_pkg::AddrDspData:  dsp_sel_d = 1'b1;
        scit_pkg::AddrPort0,
        scit_pkg::AddrPort1,
        scit_pkg::AddrPort2,
        scit_pkg::AddrPort3:    out_d.read_data = h2c_q[item_q.io_address[1:0]];
        scit_pkg::AddrScratch0,
        scit_pkg::AddrScratch1: out_d.read_data = scratch_q[item_q.io_address[0]];
        scit_pkg::AddrEvent0:   out_d.read_data = {4'd0, evt[0]};
        scit_pkg::AddrEvent1:   out_d.read_data = {4'd0, evt[1]};
        scit_pkg::AddrEvent2:   out_d.read_data = {4'd0, evt[2]};
        default: ;
      endcase
    end

    if (is_wr) begin
      case (item_q.io_address)
        scit_pkg::AddrControl: begin
          control_d = item_q.write_data;
          if (item_q.write_data[scit_pkg::CtlPortsLoBit]) begin
            h2c_d[0] = 8'd0;
            h2c_d[1] = 8'd0;
          end
          if (item_q.write_data[scit_pkg::CtlPortsHiBit]) begin
            h2c_d[2] = 8'd0;
            h2c_d[3] = 8'd0;
          end
        end
        scit_pkg::AddrDspIndex: dsp_index_d = item_q.write_data;
        scit_pkg::AddrDspData:  dsp_wr = !dsp_index_q[scit_pkg::DspLockBit];
        scit_pkg::AddrPort0,
        scit_pkg::AddrPort1,
        scit_pkg::AddrPort2,
        scit_pkg::AddrPort3:    c2h_d[item_q.io_address[1:0]] = item_q.write_data;
        scit_pkg::AddrScratch0,
        scit_pkg::AddrScratch1: scratch_d[item_q.io_address[0]] = item_q.write_data;
        default: ;
      endcase
    end

    if (is_hwr) begin
      h2c_d[item_q.port_select] = item_q.write_data;
    end
    if (is_hrd) begin
      out_d.read_data = c2h_q[item_q.port_select];
    end

    out_d.rom_overlay = control_d[scit_pkg::CtlRomBit];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_q   <= '0;
      dsp_index_q <= '0;
      h2c_q       <= '{default: '0};
      c2h_q       <= '{default: '0};
      scratch_q   <= '{default: '0};
    end else begin
      control_q   <= control_d;
      dsp_index_q <= dsp_index_d;
      h2c_q       <= h2c_d;
      c2h_q       <= c2h_d;
      scratch_q   <= scratch_d;
    end
  end

  scit_dsp_store u_dsp_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (dsp_wr),
    .rd_en_i (adv && dsp_sel_d),
    .addr_i  (dsp_index_q[scit_pkg::DspAddrW-1:0]),
    .wdata_i (item_q.write_data),
    .rdata_o (dsp_rdata)
  );

  for (genvar i = 0; i < scit_pkg::NumTimers; i++) begin : g_tmr
    always_comb begin
      tmr_ctl[i].tick    = is_tick;
      tmr_ctl[i].cycles  = item_q.tick_cycles;
      tmr_ctl[i].ctl_wr  = is_wr && (item_q.io_address == scit_pkg::AddrControl);
      tmr_ctl[i].en      = item_q.write_data[i];
      tmr_ctl[i].goal_wr = is_wr && (item_q.io_address == scit_pkg::AddrGoal0 + 4'(i));
      tmr_ctl[i].goal    = item_q.write_data;
      tmr_ctl[i].evt_rd  = is_rd && (item_q.io_address == scit_pkg::AddrEvent0 + 4'(i));
    end

    scit_timer u_timer (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .fast_i        (i == scit_pkg::NumTimers - 1),
      .ctl_i         (tmr_ctl[i]),
      .event_count_o (evt[i])
    );
  end

  assign out_valid_o           = out_valid_q;
  assign out_data_o.read_data  = dsp_sel_q ? dsp_rdata : out_q.read_data;
  assign out_data_o.rom_overlay = out_q.rom_overlay;

  `SCIT_ASSERT_NOW(a_stall_needs_item, in_stall_o, item_valid_q)
  `SCIT_ASSERT_NEXT(a_accept_fills, in_valid_i && !in_stall_o, item_valid_q)
  `SCIT_ASSERT_NOW(a_dsp_sel_with_result, dsp_sel_q, out_valid_q)
  `SCIT_ASSERT_NEXT(a_drain_empties, out_valid_q && !out_stall_i && !item_valid_q,
                    !out_valid_q)

endmodule

`default_nettype wire

// File: hw/rtl/scit_timer.sv
// ----------------------------------------------------------------------------
// Sound CPU interval timer
// Prescaler, divider with goal and 4-bit event counter for one timer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sound_cpu_io_timer_block_unit_macros.svh"

module scit_timer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fast_i,
  input  wire scit_pkg::tmr_ctl_t ctl_i,
  output logic [3:0]             event_count_o
);

  logic                        en_q, en_d;
  logic [8:0]                  goal_q, goal_d;
  logic [scit_pkg::PrescW-1:0] pre_q, pre_d;
  logic [7:0]                  div_q, div_d;
  logic [3:0]                  evt_q, evt_d;
  logic [scit_pkg::PrescW:0]   presc;
  logic [scit_pkg::PrescW:0]   sum;
  logic                        wrap;
  logic [8:0]                  div_next;

  assign presc = fast_i ? (scit_pkg::PrescW+1)'(scit_pkg::FastPrescale)
                        : (scit_pkg::PrescW+1)'(scit_pkg::SlowPrescale);
  assign sum      = {1'b0, pre_q} + (scit_pkg::PrescW+1)'(ctl_i.cycles);
  assign wrap     = sum >= presc;
  assign div_next = {1'b0, div_q} + 9'd1;

  always_comb begin
    en_d   = en_q;
    goal_d = goal_q;
    pre_d  = pre_q;
    div_d  = div_q;
    evt_d  = evt_q;
    if (ctl_i.tick && en_q) begin
      pre_d = wrap ? (scit_pkg::PrescW)'(sum - presc) : (scit_pkg::PrescW)'(sum);
      if (wrap) begin
        if (div_next >= goal_q) begin
          div_d = '0;
          evt_d = evt_q + 4'd1;
        end else begin
          div_d = div_next[7:0];
        end
      end
    end
    if (ctl_i.ctl_wr) begin
      en_d = ctl_i.en;
      if (ctl_i.en && !en_q) begin
        pre_d = '0;
        div_d = '0;
        evt_d = '0;
      end
    end
    if (ctl_i.goal_wr) begin
      goal_d = (ctl_i.goal == 8'd0) ? scit_pkg::GoalMax : {1'b0, ctl_i.goal};
    end
    if (ctl_i.evt_rd) begin
      evt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= 1'b0;
      goal_q <= scit_pkg::GoalMax;
      pre_q  <= '0;
      div_q  <= '0;
      evt_q  <= '0;
    end else begin
      en_q   <= en_d;
      goal_q <= goal_d;
      pre_q  <= pre_d;
      div_q  <= div_d;
      evt_q  <= evt_d;
    end
  end

  assign event_count_o = evt_q;

  `SCIT_ASSERT_NOW(a_pre_below_period, 1'b1, {1'b0, pre_q} < presc)
  `SCIT_ASSERT_NOW(a_goal_nonzero, 1'b1, goal_q != 9'd0 && goal_q <= scit_pkg::GoalMax)
  `SCIT_ASSERT_NEXT(a_idle_holds, !en_q && !ctl_i.ctl_wr, $stable(pre_q) && $stable(div_q))

endmodule

`default_nettype wire

// File: hw/rtl/scit_dsp_store.sv
// ----------------------------------------------------------------------------
// Sound CPU DSP register store
// Single-port byte memory with per-entry valid bits and registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module scit_dsp_store (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          wr_en_i,
  input  wire logic                          rd_en_i,
  input  wire logic [scit_pkg::DspAddrW-1:0] addr_i,
  input  wire logic [7:0]                    wdata_i,
  output logic [7:0]                         rdata_o
);

  logic [7:0]                    mem [scit_pkg::DspWords];
  logic [scit_pkg::DspWords-1:0] vld_q;
  logic [7:0]                    rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= vld_q[addr_i] ? mem[addr_i] : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[addr_i] <= 1'b1;
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: tb/sound_cpu_io_timer_block_unit_tb.sv
// ----------------------------------------------------------------------------
// Sound CPU I/O page testbench
// Sends CPU reads and writes, timer ticks and host port traffic through the
// valid/stall channels. A scoreboard class keeps its own copy of the page and
// the three timers, predicts one response per transfer, and compares each
// response, field by field, in order. Sender gaps and receiver stalls vary by
// phase.
// ----------------------------------------------------------------------------
import scit_pkg::*;

class io_page_scoreboard;
  logic [7:0]  ctl_reg;
  logic [7:0]  dsp_ptr;
  logic [7:0]  dsp_mem [DspWords];
  logic [7:0]  port_in [4];
  logic [7:0]  port_out [4];
  logic [7:0]  scratch [2];
  logic        tmr_on [NumTimers];
  logic [8:0]  tmr_goal [NumTimers];
  int unsigned tmr_presc [NumTimers];
  logic [7:0]  tmr_div [NumTimers];
  logic [3:0]  tmr_evt [NumTimers];
  int unsigned tmr_period [NumTimers];
  out_item_t   expected_q [$];
  int unsigned mismatches;
  int unsigned checked;
  int unsigned event_hits;

  function new();
    ctl_reg = '0;
    dsp_ptr = '0;
    foreach (dsp_mem[i]) dsp_mem[i] = '0;
    foreach (port_in[i]) begin
      port_in[i]  = '0;
      port_out[i] = '0;
    end
    foreach (scratch[i]) scratch[i] = '0;
    for (int t = 0; t < NumTimers; t++) begin
      tmr_on[t]     = 1'b0;
      tmr_goal[t]   = GoalMax;
      tmr_presc[t]  = 0;
      tmr_div[t]    = '0;
      tmr_evt[t]    = '0;
      tmr_period[t] = (t == NumTimers - 1) ? FastPrescale : SlowPrescale;
    end
    mismatches = 0;
    checked    = 0;
    event_hits = 0;
  endfunction

  function out_item_t page_access_result(in_item_t item);
    out_item_t  res;
    logic [7:0] rd;
    logic [8:0] stepped;
    int         idx;
    rd = '0;
    case (item.func)
      FUNC_CPU_RD: begin
        case (item.io_address)
          AddrDspIndex: rd = dsp_ptr;
          AddrDspData:  rd = dsp_mem[dsp_ptr[DspAddrW-1:0]];
          AddrPort0, AddrPort1, AddrPort2, AddrPort3:
            rd = port_in[int'(item.io_address - AddrPort0)];
          AddrScratch0, AddrScratch1:
            rd = scratch[int'(item.io_address - AddrScratch0)];
          AddrEvent0, AddrEvent1, AddrEvent2: begin
            idx = int'(item.io_address - AddrEvent0);
            rd = {4'h0, tmr_evt[idx]};
            tmr_evt[idx] = '0;
            if (rd != '0) event_hits++;
          end
          default: ;
        endcase
      end
      FUNC_CPU_WR: begin
        case (item.io_address)
          AddrControl: begin
            ctl_reg = item.write_data;
            for (int t = 0; t < NumTimers; t++) begin
              if (item.write_data[t] && !tmr_on[t]) begin
                tmr_presc[t] = 0;
                tmr_div[t]   = '0;
                tmr_evt[t]   = '0;
              end
              tmr_on[t] = item.write_data[t];
            end
            if (item.write_data[CtlPortsLoBit]) begin
              port_in[0] = '0;
              port_in[1] = '0;
            end
            if (item.write_data[CtlPortsHiBit]) begin
              port_in[2] = '0;
              port_in[3] = '0;
            end
          end
          AddrDspIndex: dsp_ptr = item.write_data;
          AddrDspData:
            if (!dsp_ptr[DspLockBit]) dsp_mem[dsp_ptr[DspAddrW-1:0]] = item.write_data;
          AddrPort0, AddrPort1, AddrPort2, AddrPort3:
            port_out[int'(item.io_address - AddrPort0)] = item.write_data;
          AddrScratch0, AddrScratch1:
            scratch[int'(item.io_address - AddrScratch0)] = item.write_data;
          AddrGoal0, AddrGoal1, AddrGoal2:
            tmr_goal[int'(item.io_address - AddrGoal0)] =
              (item.write_data == '0) ? GoalMax : {1'b0, item.write_data};
          default: ;
        endcase
      end
      FUNC_TICK: begin
        for (int t = 0; t < NumTimers; t++) begin
          if (tmr_on[t]) begin
            tmr_presc[t] += 32'(item.tick_cycles);
            while (tmr_presc[t] >= tmr_period[t]) begin
              tmr_presc[t] -= tmr_period[t];
              stepped = {1'b0, tmr_div[t]} + 9'd1;
              if (stepped >= tmr_goal[t]) begin
                tmr_div[t] = '0;
                tmr_evt[t] = tmr_evt[t] + 4'd1;
              end else begin
                tmr_div[t] = stepped[7:0];
              end
            end
          end
        end
      end
      FUNC_HOST_WR: port_in[item.port_select] = item.write_data;
      FUNC_HOST_RD: rd = port_out[item.port_select];
      default: ;
    endcase
    res.read_data   = rd;
    res.rom_overlay = ctl_reg[CtlRomBit];
    return res;
  endfunction

  function void note_transfer(in_item_t item);
    expected_q.insert(expected_q.size(), page_access_result(item));
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    checked++;
    if (expected_q.size() == 0) begin
      mismatches++;
      $error("response with no pending transfer: read_data %02h rom_overlay %0b",
             got.read_data, got.rom_overlay);
      return;
    end
    want = expected_q.pop_front();
    if (got.read_data !== want.read_data) begin
      mismatches++;
      $error("read_data: expected %02h, actual %02h", want.read_data, got.read_data);
    end
    if (got.rom_overlay !== want.rom_overlay) begin
      mismatches++;
      $error("rom_overlay: expected %0b, actual %0b", want.rom_overlay, got.rom_overlay);
    end
  endfunction
endclass

module sound_cpu_io_timer_block_unit_tb;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned PhaseItems   = 350;
  localparam int unsigned LongRunTicks = 300;
  localparam logic [2:0]  FuncBadFirst = 3'd5;
  localparam logic [2:0]  FuncBadLast  = 3'd7;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  in_item_t    in_data_i   = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  out_item_t   out_data_o;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  int unsigned transfers      = 0;
  io_page_scoreboard sb;

  sound_cpu_io_timer_block_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic issue(logic [2:0] f, logic [3:0] a, logic [7:0] d, logic [1:0] p,
                       logic [3:0] c);
    in_item_t item;
    item.func        = f;
    item.io_address  = a;
    item.write_data  = d;
    item.port_select = p;
    item.tick_cycles = c;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    sb.note_transfer(item);
    transfers++;
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned items);
    int unsigned start;
    int unsigned timer;
    int unsigned sel;
    logic [7:0]  goal;
    start = transfers;
    while (transfers - start < items) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          timer = $urandom_range(NumTimers - 1);
          goal  = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 6));
          issue(FUNC_CPU_WR, 4'(AddrGoal0 + timer), goal, 2'($urandom), 4'($urandom));
          issue(FUNC_CPU_WR, AddrControl, 8'($urandom), 2'($urandom), 4'($urandom));
          repeat ($urandom_range(4, 40)) begin
            if ($urandom_range(7) == 0)
              issue(FUNC_CPU_RD, 4'(AddrEvent0 + $urandom_range(2)), 8'($urandom),
                    2'($urandom), 4'($urandom));
            else
              issue(FUNC_TICK, 4'($urandom), 8'($urandom), 2'($urandom),
                    4'($urandom_range(15)));
          end
          for (int t = 0; t < NumTimers; t++)
            issue(FUNC_CPU_RD, 4'(AddrEvent0 + t), 8'($urandom), 2'($urandom),
                  4'($urandom));
        end
        5, 6, 7: begin
          sel = $urandom_range(3);
          case ($urandom_range(3))
            0: begin
              issue(FUNC_CPU_WR, AddrDspIndex, 8'($urandom), 2'($urandom), 4'($urandom));
              issue(FUNC_CPU_WR, AddrDspData, 8'($urandom), 2'($urandom), 4'($urandom));
              issue(FUNC_CPU_RD, AddrDspData, 8'($urandom), 2'($urandom), 4'($urandom));
              issue(FUNC_CPU_RD, AddrDspIndex, 8'($urandom), 2'($urandom), 4'($urandom));
            end
            1: begin
              issue(FUNC_HOST_WR, 4'($urandom), 8'($urandom), 2'(sel), 4'($urandom));
              issue(FUNC_CPU_RD, 4'(AddrPort0 + sel), 8'($urandom), 2'($urandom),
                    4'($urandom));
              sel = $urandom_range(3);
              issue(FUNC_CPU_WR, 4'(AddrPort0 + sel), 8'($urandom), 2'($urandom),
                    4'($urandom));
              issue(FUNC_HOST_RD, 4'($urandom), 8'($urandom), 2'(sel), 4'($urandom));
            end
            2: begin
              sel = $urandom_range(1);
              issue(FUNC_CPU_WR, 4'(AddrScratch0 + sel), 8'($urandom), 2'($urandom),
                    4'($urandom));
              issue(FUNC_CPU_RD, 4'(AddrScratch0 + sel), 8'($urandom), 2'($urandom),
                    4'($urandom));
            end
            default:
              issue(FUNC_CPU_RD, 4'($urandom), 8'($urandom), 2'($urandom), 4'($urandom));
          endcase
        end
        default:
          repeat (4)
            issue(3'($urandom), 4'($urandom), 8'($urandom), 2'($urandom), 4'($urandom));
      endcase
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(FUNC_CPU_RD, AddrEvent0, 8'h00, 2'd0, 4'h0);
    issue(FUNC_CPU_RD, AddrControl, 8'hFF, 2'd3, 4'hF);
    issue(FUNC_HOST_WR, 4'h0, 8'hFF, 2'd3, 4'hF);
    issue(FUNC_CPU_RD, AddrPort3, 8'h00, 2'd0, 4'h0);
    issue(FUNC_CPU_WR, AddrPort0, 8'hA5, 2'd2, 4'h0);
    issue(FUNC_HOST_RD, 4'hF, 8'h00, 2'd0, 4'h0);
    issue(FUNC_CPU_WR, AddrScratch1, 8'hFF, 2'd1, 4'hF);
    issue(FUNC_CPU_RD, AddrScratch1, 8'h00, 2'd0, 4'h0);
    issue(FUNC_CPU_WR, AddrDspIndex, 8'h85, 2'd0, 4'h0);
    issue(FUNC_CPU_WR, AddrDspData, 8'hAA, 2'd0, 4'h0);
    issue(FUNC_CPU_RD, AddrDspData, 8'h00, 2'd0, 4'h0);
    issue(FUNC_CPU_RD, AddrDspIndex, 8'h00, 2'd0, 4'h0);
    issue(FUNC_CPU_WR, AddrDspIndex, 8'h7F, 2'd0, 4'h0);
    issue(FUNC_CPU_WR, AddrDspData, 8'h55, 2'd0, 4'h0);
    issue(FUNC_CPU_RD, AddrDspData, 8'h00, 2'd0, 4'h0);
    // lift the divider under a goal of 256, then drop the goal below it
    issue(FUNC_CPU_WR, AddrGoal2, 8'h00, 2'd0, 4'h0);
    issue(FUNC_CPU_WR, AddrControl, 8'h84, 2'd0, 4'h0);
    repeat (3) issue(FUNC_TICK, 4'h0, 8'h00, 2'd0, 4'hF);
    issue(FUNC_CPU_WR, AddrGoal2, 8'h01, 2'd0, 4'h0);
    issue(FUNC_TICK, 4'h0, 8'h00, 2'd0, 4'hF);
    issue(FUNC_CPU_RD, AddrEvent2, 8'h00, 2'd0, 4'h0);
    issue(FUNC_CPU_RD, AddrEvent0, 8'h00, 2'd0, 4'h0);
    issue(FUNC_CPU_WR, AddrControl, 8'h30, 2'd0, 4'h0);
    issue(FUNC_CPU_RD, AddrPort3, 8'h00, 2'd0, 4'h0);
    issue(FuncBadLast, AddrControl, 8'hFF, 2'd3, 4'hF);
    issue(FuncBadFirst, AddrDspIndex, 8'hFF, 2'd3, 4'hF);
    issue(FUNC_CPU_WR, 4'h0, 8'hFF, 2'd0, 4'h0);
    issue(FUNC_CPU_WR, AddrEvent1, 8'hFF, 2'd0, 4'h0);
    wait_for_drain();

    send_idle_pct  = 15;
    recv_stall_pct = 51;
    run_phase(PhaseItems);
    wait_for_drain();

    send_idle_pct  = 51;
    recv_stall_pct = 15;
    run_phase(PhaseItems);
    wait_for_drain();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_phase(PhaseItems);
    // run the fast timer long enough to wrap a full 256 goal
    issue(FUNC_CPU_WR, AddrControl, 8'h00, 2'd0, 4'h0);
    issue(FUNC_CPU_WR, AddrGoal2, 8'h00, 2'd0, 4'h0);
    issue(FUNC_CPU_WR, AddrControl, 8'h04, 2'd0, 4'h0);
    repeat (LongRunTicks) issue(FUNC_TICK, 4'($urandom), 8'($urandom), 2'($urandom), 4'hF);
    issue(FUNC_CPU_RD, AddrEvent2, 8'h00, 2'd0, 4'h0);
    wait_for_drain();
    repeat (10) @(posedge clk_i);

    $display("Run covered %0d transfers across three gap and stall mixes.", transfers);
    $display("Checked %0d responses; %0d timer event reads returned a nonzero count.",
             sb.checked, sb.event_hits);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/scit_pkg.sv
hw/rtl/scit_timer.sv
hw/rtl/scit_dsp_store.sv
hw/rtl/sound_cpu_io_timer_block_unit.sv
tb/sound_cpu_io_timer_block_unit_tb.sv
